// ===== sv/mkd_pkg.sv =====
package mkd_pkg;

   localparam int KEY_W  = 4;
   localparam int CNT_W  = 3;
   localparam int CHAR_W = 7;

   // request kinds (tuser on the request channel)
   localparam logic REQ_PRESS = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   // result kinds (tuser on the response channel)
   localparam logic KIND_APPEND = 1'b0;
   localparam logic KIND_DELETE = 1'b1;

   localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
   localparam logic [KEY_W-1:0] KEY_HASH      = 4'd10;
   localparam logic [KEY_W-1:0] KEY_STAR      = 4'd11;

   typedef struct packed {
      logic              kind;
      logic [CHAR_W-1:0] char_code;
   } result_type;

   typedef struct packed {
      logic       push;
      result_type result;
   } push_type;

   // letters a digit key steps through
   function automatic logic [CNT_W:0] key_len(input logic [KEY_W-1:0] key);
      logic [CNT_W:0] len;
      case (key)
         4'd0:    len = 4'd2;
         4'd1:    len = 4'd8;
         4'd7:    len = 4'd5;
         4'd9:    len = 4'd5;
         default: len = 4'd4;
      endcase
      return len;
   endfunction

   function automatic logic [CHAR_W-1:0] key_char(input logic [KEY_W-1:0] key,
                                                  input logic [CNT_W-1:0] cnt);
      logic [7:0] row [8];
      case (key)
         4'd0:    row = '{" ", "0", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
         4'd1:    row = '{".", "?", "!", ",", "/", "_", "-", "1"};
         4'd2:    row = '{"A", "B", "C", "2", 8'h00, 8'h00, 8'h00, 8'h00};
         4'd3:    row = '{"D", "E", "F", "3", 8'h00, 8'h00, 8'h00, 8'h00};
         4'd4:    row = '{"G", "H", "I", "4", 8'h00, 8'h00, 8'h00, 8'h00};
         4'd5:    row = '{"J", "K", "L", "5", 8'h00, 8'h00, 8'h00, 8'h00};
         4'd6:    row = '{"M", "N", "O", "6", 8'h00, 8'h00, 8'h00, 8'h00};
         4'd7:    row = '{"P", "Q", "R", "S", "7", 8'h00, 8'h00, 8'h00};
         4'd8:    row = '{"T", "U", "V", "8", 8'h00, 8'h00, 8'h00, 8'h00};
         4'd9:    row = '{"W", "X", "Y", "Z", "9", 8'h00, 8'h00, 8'h00};
         default: row = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      endcase
      return row[cnt][CHAR_W-1:0];
   endfunction

endpackage

// ===== sv/multitap_keypad_decoder_top.sv =====
// channel   dir  tdata                 tuser
// req       in   [3:0] key_code        [0] req_type
// rsp       out  [6:0] out_char        [0] out_kind
//
// One transaction per cycle sustained while responses are taken; a result
// passes through the input register, then the two-entry result queue.
// The pending key and press count update in the single decode pass.
// Reset is synchronous and clears the pending state, the input register and the result queue.
// A stalled response holds; requests keep flowing until the queue is full.
module multitap_keypad_decoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [3:0] key_code, [7:4] zero
   input  logic       req_tuser,   // [0] req_type
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] out_char, [7] zero
   output logic       rsp_tuser    // [0] out_kind
);

   mkd_pkg::push_type   push;
   mkd_pkg::result_type rsp_result;
   logic                space;

   mkd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_tuser),
      .req_key    (req_tdata[mkd_pkg::KEY_W-1:0]),
      .space      (space),
      .push       (push)
   );

   mkd_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {1'b0, rsp_result.char_code};
   assign rsp_tuser = rsp_result.kind;

endmodule

// ===== sv/mkd_core.sv =====
module mkd_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic                        req_type,
   input  logic [mkd_pkg::KEY_W-1:0]   req_key,
   input  logic                        space,
   output mkd_pkg::push_type           push
);

   logic                        in_valid_ff, in_valid_in;
   logic                        in_type_ff;
   logic [mkd_pkg::KEY_W-1:0]   in_key_ff;

   logic [mkd_pkg::KEY_W-1:0]   pend_key_ff, pend_key_in;
   logic                        pend_valid_ff, pend_valid_in;
   logic [mkd_pkg::CNT_W-1:0]   count_ff, count_in;

   logic                        advance;
   logic                        is_flush, is_hash, is_star, is_digit, same_key;
   logic [mkd_pkg::CNT_W:0]     next_count;

   assign advance    = in_valid_ff && space;
   assign req_tready = !in_valid_ff || space;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_type_ff <= req_type;
         in_key_ff  <= req_key;
      end
   end

   always_comb begin
      is_flush = in_type_ff == mkd_pkg::REQ_FLUSH;
      is_hash  = !is_flush && in_key_ff == mkd_pkg::KEY_HASH;
      is_star  = !is_flush && in_key_ff == mkd_pkg::KEY_STAR;
      is_digit = !is_flush && in_key_ff <= mkd_pkg::KEY_DIGIT_MAX;
      same_key = pend_valid_ff && pend_key_ff == in_key_ff;
      next_count = {1'b0, count_ff} + 4'd1;
   end

   always_comb begin
      push.push             = 1'b0;
      push.result.kind      = mkd_pkg::KIND_APPEND;
      push.result.char_code = mkd_pkg::key_char(pend_key_ff, count_ff);
      if (advance) begin
         if (is_star) begin
            push.push             = 1'b1;
            push.result.kind      = mkd_pkg::KIND_DELETE;
            push.result.char_code = '0;
         end else if (is_flush || is_hash || (is_digit && !same_key)) begin
            push.push = pend_valid_ff;
         end
      end
   end

   always_comb begin
      pend_key_in   = pend_key_ff;
      pend_valid_in = pend_valid_ff;
      count_in      = count_ff;
      if (advance) begin
         if (is_flush || is_hash) begin
            pend_key_in   = '0;
            pend_valid_in = 1'b0;
            count_in      = '0;
         end else if (is_digit && same_key) begin
            // wrap to the first letter after the last
            if (next_count >= mkd_pkg::key_len(in_key_ff)) begin
               count_in = '0;
            end else begin
               count_in = next_count[mkd_pkg::CNT_W-1:0];
            end
         end else if (is_digit) begin
            pend_key_in   = in_key_ff;
            pend_valid_in = 1'b1;
            count_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_key_ff   <= '0;
         pend_valid_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         pend_key_ff   <= pend_key_in;
         pend_valid_ff <= pend_valid_in;
         count_ff      <= count_in;
      end
   end

endmodule

// ===== sv/mkd_out_buf.sv =====
module mkd_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  mkd_pkg::push_type    push,
   output logic                 space,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output mkd_pkg::result_type  rsp_result
);

   mkd_pkg::result_type entry_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                pop;

   assign space      = count_ff != 2'd2;
   assign rsp_tvalid = count_ff != 2'd0;
   assign rsp_result = entry_ff[rd_ptr_ff];
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      wr_ptr_in = push.push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push.push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.push) begin
         entry_ff[wr_ptr_ff] <= push.result;
      end
   end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [mkd_pkg::KEY_W-1:0] key_code_type;

   typedef struct packed {
      logic                       kind;
      logic [mkd_pkg::CHAR_W-1:0] char_code;
   } char_item_type;

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [3:0] key_code, [7:4] zero
   logic       req_tuser  = 1'b0;    // [0] req_type
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [6:0] out_char, [7] zero
   logic       rsp_tuser;            // [0] out_kind

   // predicted keypad state
   key_code_type              held_key   = '0;
   logic                      held_valid = 1'b0;
   logic [mkd_pkg::CNT_W-1:0] held_count = '0;

   char_item_type due_chars [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int err_count     = 0;
   int items_sent    = 0;
   int ignored_sent  = 0;
   int appends_seen  = 0;
   int deletes_seen  = 0;

   multitap_keypad_decoder_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("** multitap_keypad_decoder_top: FAILED **");
      $finish;
   end

   function automatic string key_letters(input key_code_type key);
      case (key)
         4'd0:    return " 0";
         4'd1:    return ".?!,/_-1";
         4'd2:    return "ABC2";
         4'd3:    return "DEF3";
         4'd4:    return "GHI4";
         4'd5:    return "JKL5";
         4'd6:    return "MNO6";
         4'd7:    return "PQRS7";
         4'd8:    return "TUV8";
         default: return "WXYZ9";
      endcase
   endfunction

   // queue the held character, if any
   task automatic emit_held();
      char_item_type item;
      string         row;
      byte           letter;
      if (held_valid) begin
         row            = key_letters(held_key);
         letter         = row[held_count];
         item.kind      = mkd_pkg::KIND_APPEND;
         item.char_code = letter[mkd_pkg::CHAR_W-1:0];
         due_chars.push_back(item);
      end
   endtask

   task automatic decode_key(input logic req_type, input key_code_type key_code);
      char_item_type item;
      string         row;
      if (req_type == mkd_pkg::REQ_FLUSH || key_code == mkd_pkg::KEY_HASH) begin
         emit_held();
         held_key   = '0;
         held_valid = 1'b0;
         held_count = '0;
      end else if (key_code == mkd_pkg::KEY_STAR) begin
         item.kind      = mkd_pkg::KIND_DELETE;
         item.char_code = '0;
         due_chars.push_back(item);
      end else if (key_code <= mkd_pkg::KEY_DIGIT_MAX) begin
         if (held_valid && held_key == key_code) begin
            row = key_letters(key_code);
            // wrap past the last letter of the key
            if (int'(held_count) + 1 >= row.len())
               held_count = '0;
            else
               held_count = held_count + 1'b1;
         end else begin
            emit_held();
            held_key   = key_code;
            held_valid = 1'b1;
            held_count = '0;
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_rsp
      char_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_chars.size() == 0) begin
            $error("unexpected result transaction: out_kind %0d out_char 0x%02h",
                   rsp_tuser, rsp_tdata[mkd_pkg::CHAR_W-1:0]);
            err_count++;
         end else begin
            want = due_chars.pop_front();
            if (rsp_tuser !== want.kind) begin
               $error("out_kind: expected %0d, got %0d", want.kind, rsp_tuser);
               err_count++;
            end
            if (rsp_tdata[mkd_pkg::CHAR_W-1:0] !== want.char_code) begin
               $error("out_char: expected 0x%02h, got 0x%02h",
                      want.char_code, rsp_tdata[mkd_pkg::CHAR_W-1:0]);
               err_count++;
            end
            if (want.kind == mkd_pkg::KIND_DELETE)
               deletes_seen++;
            else
               appends_seen++;
         end
      end
   end

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic send_key(input logic req_type, input key_code_type key_code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= req_type;
      req_tdata  <= {4'b0000, key_code};
      do @(posedge clock); while (!req_tready);
      decode_key(req_type, key_code);
      if (req_type == mkd_pkg::REQ_PRESS && key_code > mkd_pkg::KEY_STAR)
         ignored_sent++;
      else
         items_sent++;
      @(negedge clock);
   endtask

   // hold off until every expected result is in, then let the pipe settle
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (due_chars.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic test_directed_cases();
      send_key(mkd_pkg::REQ_FLUSH, 4'd0);              // flush with nothing held
      send_key(mkd_pkg::REQ_PRESS, mkd_pkg::KEY_HASH); // hash with nothing held
      send_key(mkd_pkg::REQ_PRESS, mkd_pkg::KEY_STAR); // delete with no prior character
      send_key(mkd_pkg::REQ_PRESS, 4'd12);
      send_key(mkd_pkg::REQ_PRESS, 4'd15);
      repeat (9) send_key(mkd_pkg::REQ_PRESS, 4'd1);   // wraps back to the first letter
      send_key(mkd_pkg::REQ_PRESS, 4'd13);             // unused code while a key is held
      send_key(mkd_pkg::REQ_PRESS, 4'd0);
      send_key(mkd_pkg::REQ_PRESS, 4'd0);
      send_key(mkd_pkg::REQ_PRESS, mkd_pkg::KEY_STAR); // held key survives a delete
      send_key(mkd_pkg::REQ_PRESS, 4'd0);
      send_key(mkd_pkg::REQ_PRESS, mkd_pkg::KEY_HASH);
      repeat (5) send_key(mkd_pkg::REQ_PRESS, 4'd9);
      send_key(mkd_pkg::REQ_PRESS, 4'd14);
      send_key(mkd_pkg::REQ_FLUSH, 4'hF);              // key code ignored on flush
      drain_results();
   endtask

   task automatic type_word();
      int           n_letters;
      int           presses;
      key_code_type digit;
      key_code_type last_digit;
      bit           have_last;
      n_letters  = $urandom_range(1, 6);
      have_last  = 1'b0;
      last_digit = '0;
      for (int i = 0; i < n_letters; i++) begin
         digit = key_code_type'($urandom_range(0, 9));
         // separate two letters on the same key
         if (have_last && digit == last_digit)
            send_key(mkd_pkg::REQ_PRESS, mkd_pkg::KEY_HASH);
         presses = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 17) : $urandom_range(1, 4);
         repeat (presses) send_key(mkd_pkg::REQ_PRESS, digit);
         if ($urandom_range(0, 9) == 0)
            send_key(mkd_pkg::REQ_PRESS, mkd_pkg::KEY_STAR);
         last_digit = digit;
         have_last  = 1'b1;
      end
      if ($urandom_range(0, 2) == 0)
         send_key(mkd_pkg::REQ_PRESS, mkd_pkg::KEY_HASH);
      else
         send_key(mkd_pkg::REQ_FLUSH, key_code_type'($urandom_range(0, 15)));
   endtask

   task automatic test_random_entry(input int snd_pct, input int rcv_pct, input int n_items);
      int stop_at;
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      stop_at       = items_sent + n_items;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0)
            send_key(1'($urandom_range(0, 1)), key_code_type'($urandom_range(0, 15)));
         else
            type_word();
      end
      drain_results();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_random_entry(23, 62, 670);
      test_random_entry(62, 23, 670);
      test_random_entry(0, 0, 670);

      if (due_chars.size() != 0) begin
         $error("%0d expected results never arrived", due_chars.size());
         err_count++;
      end
      $display("Sent %0d keypad requests plus %0d unused codes under three idle patterns;",
               items_sent, ignored_sent);
      $display("checked %0d appended and %0d deleted characters.", appends_seen, deletes_seen);
      if (err_count == 0)
         $display("** multitap_keypad_decoder_top: PASSED **");
      else
         $display("** multitap_keypad_decoder_top: FAILED **");
      $finish;
   end

endmodule
